/* rtl/lru_pkg.sv */
// Shared constants and types for the age-counter victim selector.
package lru_pkg;

   localparam int NUM_FRAMES      = 16;
   localparam int AGE_WIDTH       = 16;
   localparam int FRAME_IDX_WIDTH = $clog2(NUM_FRAMES);

   // Widths of the request and response payload fields.
   localparam int REQ_INDEX_WIDTH = 4;
   localparam int RSP_INDEX_WIDTH = 4;
   localparam int RSP_AGE_WIDTH   = 16;

   typedef enum logic {
      OP_ACCESS = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic load_result;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_frame;
   } dp_status_type;

endpackage

/* rtl/lru_if.sv */
// Valid/ready channel interfaces for requests and responses.
interface lru_req_if
   import lru_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [REQ_INDEX_WIDTH-1:0] frame_index;

   modport source (output valid, output opcode, output frame_index, input ready);
   modport sink (input valid, input opcode, input frame_index, output ready);
endinterface

interface lru_rsp_if
   import lru_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [RSP_INDEX_WIDTH-1:0] victim_frame;
   logic [RSP_AGE_WIDTH-1:0]   victim_age;
   logic                       victim_in_use;

   modport source (output valid, output victim_frame, output victim_age,
                   output victim_in_use, input ready);
   modport sink (input valid, input victim_frame, input victim_age,
                 input victim_in_use, output ready);
endinterface

/* rtl/lru_ctrl.sv */
// Controller state machine: request intake, frame sweep and response handoff.
module lru_ctrl
   import lru_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.start       = 1'b0;
      cmd.step        = 1'b0;
      cmd.load_result = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.step = 1'b1;
            if (status.last_frame) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold the finished result until the response register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_result | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/lru_dp.sv */
// Datapath: per-frame age and in-use registers, sweep counter and oldest-frame search.
module lru_dp
   import lru_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_opcode,
   input  logic [REQ_INDEX_WIDTH-1:0] req_frame_index,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic [RSP_INDEX_WIDTH-1:0] rsp_victim_frame,
   output logic [RSP_AGE_WIDTH-1:0]   rsp_victim_age,
   output logic                       rsp_victim_in_use
);

   localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
   localparam int CMP_WIDTH =
      (FRAME_IDX_WIDTH > REQ_INDEX_WIDTH) ? FRAME_IDX_WIDTH + 1 : REQ_INDEX_WIDTH + 1;

   logic [AGE_WIDTH-1:0]       age_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]      in_use_ff;
   logic [FRAME_IDX_WIDTH-1:0] count_ff;
   logic                       opcode_ff;
   logic [REQ_INDEX_WIDTH-1:0] index_ff;
   logic                       found_ff;
   logic [FRAME_IDX_WIDTH-1:0] best_idx_ff;
   logic [AGE_WIDTH-1:0]       best_age_ff;
   logic [RSP_INDEX_WIDTH-1:0] victim_frame_ff;
   logic [RSP_AGE_WIDTH-1:0]   victim_age_ff;
   logic                       victim_in_use_ff;

   logic [AGE_WIDTH-1:0] cur_age;
   logic                 cur_in_use;
   logic [AGE_WIDTH-1:0] age_in;
   logic                 in_use_in;
   logic                 hit;
   logic                 take;

   assign cur_age    = age_ff[count_ff];
   assign cur_in_use = in_use_ff[count_ff];
   assign hit        = CMP_WIDTH'(count_ff) == CMP_WIDTH'(index_ff);

   always_comb begin
      age_in    = cur_age;
      in_use_in = cur_in_use;
      if (opcode_ff == OP_CLEAR) begin
         age_in    = '0;
         in_use_in = 1'b0;
      end else if (hit) begin
         age_in    = '0;
         in_use_in = 1'b1;
      end else if (cur_in_use && cur_age != AGE_MAX) begin
         age_in = cur_age + AGE_WIDTH'(1);
      end
      // Strictly greater keeps the lowest index on a tie.
      take = in_use_in && (!found_ff || age_in > best_age_ff);
   end

   assign status.last_frame = count_ff == FRAME_IDX_WIDTH'(NUM_FRAMES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         count_ff  <= '0;
         found_ff  <= 1'b0;
      end else if (cmd.start) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.step) begin
         in_use_ff[count_ff] <= in_use_in;
         count_ff            <= count_ff + FRAME_IDX_WIDTH'(1);
         if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.step) begin
         age_ff[count_ff] <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         opcode_ff   <= req_opcode;
         index_ff    <= req_frame_index;
         best_idx_ff <= '0;
         best_age_ff <= '0;
      end else if (cmd.step && take) begin
         best_idx_ff <= count_ff;
         best_age_ff <= age_in;
      end
      if (cmd.load_result) begin
         victim_frame_ff  <= RSP_INDEX_WIDTH'(best_idx_ff);
         victim_age_ff    <= RSP_AGE_WIDTH'(best_age_ff);
         victim_in_use_ff <= found_ff;
      end
   end

   assign rsp_victim_frame  = victim_frame_ff;
   assign rsp_victim_age    = victim_age_ff;
   assign rsp_victim_in_use = victim_in_use_ff;

endmodule

/* rtl/lru_age_counter_victim_select.sv */
// Each request is accepted in the idle state; the sweep then steps through
// the sixteen frame registers one frame a cycle (ageing them and tracking
// the oldest in-use frame), and the finish state loads the response
// register. A new request is accepted while a finished response still
// waits to be taken; the block stalls only if a second response is ready
// before the first is taken.
// There is no configuration and no startup sweep after reset.
module lru_age_counter_victim_select
   import lru_pkg::*;
(
   input logic   clock,
   input logic   reset,
   lru_req_if.sink   req_bus,
   lru_rsp_if.source rsp_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;

   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lru_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_bus.opcode),
      .req_frame_index   (req_bus.frame_index),
      .cmd               (cmd),
      .status            (status),
      .rsp_victim_frame  (rsp_bus.victim_frame),
      .rsp_victim_age    (rsp_bus.victim_age),
      .rsp_victim_in_use (rsp_bus.victim_in_use)
   );

endmodule
